FILE: rtl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types, transaction codes and helpers for the life grid engine.
// ----------------------------------------------------------------------------
package lag_pkg;

  typedef enum logic [1:0] {
    KIND_TOGGLE = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_READ   = 2'd2
  } lag_kind_t;

  // input transaction
  typedef struct packed {
    lag_kind_t  kind;
    logic [5:0] row;
    logic [5:0] col;
  } lag_in_t;

  // result transaction
  typedef struct packed {
    logic        cell_value;
    logic [31:0] generation;
    logic [31:0] alive_estimate;
  } lag_out_t;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // saturating 32-bit add
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

endpackage

FILE: rtl/life_automaton_grid_engine.sv
// ----------------------------------------------------------------------------
// life_automaton_grid_engine
// B3/S23 life grid with cell toggle/read, generation step and edge eating.
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready/in_data carries one transaction: toggle a
//   cell, read a cell, or advance one generation; result channel
//   out_valid/out_ready/out_data returns exactly one transaction per input
//   toggle/read: the row is read (S_CELL_RD), the bit is selected into the
//   result register (S_CELL), then it moves to the output register (S_DONE)
//   step: the grid rows are swept once through the single-port row memory,
//   one row read per cycle into a three-row window, then a short pipeline
//   (next-state row, per-byte popcount, row sum) drains; the totals are then
//   folded in (S_FIN1, S_FIN2) before the result moves on through S_DONE
//   one transaction is in work at a time: in_ready is high only while idle
//   the finished result sits in an output register; a stalled receiver holds
//   it there and the engine may take the next transaction, which waits for
//   that register before it can deliver
//   reset: the grid reads as all dead at once (per-row valid bits, no
//   clearing pass), generation goes to 1, eaten total to 0
// ----------------------------------------------------------------------------
module life_automaton_grid_engine
  import lag_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lag_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lag_out_t out_data
);

  localparam int AW = $clog2(GRID_SIZE);          // row address
  localparam int IW = $clog2(GRID_SIZE + 1);      // sweep index 0..GRID_SIZE
  localparam int CW = $clog2(GRID_SIZE + 1);      // popcount of one row
  localparam int LW = $clog2(GRID_SIZE * GRID_SIZE + 1);
  localparam int NL = (GRID_SIZE + 7) / 8;        // byte lanes of a row
  localparam int PW = NL * 8;
  localparam logic [GRID_SIZE-1:0] EDGE_COLS = {1'b1, {(GRID_SIZE-2){1'b0}}, 1'b1};
  localparam logic [GRID_SIZE-1:0] ONE_BIT   = {{(GRID_SIZE-1){1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    S_IDLE, S_CELL_RD, S_CELL, S_STEP, S_DRAIN, S_FIN1, S_FIN2, S_DONE
  } state_t;

  state_t state_r;
  lag_in_t req_r;
  logic [IW-1:0] idx_r;

  // row memory and per-row valid bits
  logic [GRID_SIZE-1:0] grid_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld_r;
  logic [AW-1:0]        rd_addr;
  logic [GRID_SIZE-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [GRID_SIZE-1:0] wr_data;

  // three-row window and sweep pipeline
  logic [GRID_SIZE-1:0] win_prev_r, win_cur_r;
  logic                 s1_v_r;
  logic [IW-1:0]        s1_row_r;
  logic [GRID_SIZE-1:0] incoming, life_raw, life_kept;
  logic                 s1_edge;
  logic [1:0]           s1_side;
  logic                 s2_v_r, s2_edge_r;
  logic [AW-1:0]        s2_row_r;
  logic [GRID_SIZE-1:0] s2_raw_r, s2_kept_r;
  logic [1:0]           s2_side_r;
  logic [3:0]           lane_cnt [NL];
  logic                 s3_v_r, s3_edge_r;
  logic [3:0]           s3_lane_r [NL];
  logic [1:0]           s3_side_r;
  logic [CW-1:0]        lane_sum;
  logic [LW-1:0]        live_acc_r, eaten_acc_r;

  logic [31:0] gen_r, eaten_total_r;
  lag_out_t    res_r, out_data_r;
  logic        out_valid_r;

  // cell access
  logic                 req_inside;
  logic [GRID_SIZE-1:0] row_bits;
  logic                 cur_bit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign req_inside = (int'(req_r.row) < GRID_SIZE) && (int'(req_r.col) < GRID_SIZE);
  assign row_bits   = rd_vld_r ? rd_data_r : '0;
  assign cur_bit    = req_inside ? row_bits[AW'(req_r.col)] : 1'b0;

  // read address: requested row, or the sweep index
  always_comb begin
    rd_addr = AW'(req_r.row);
    if (state_r == S_STEP) begin
      rd_addr = idx_r[AW-1:0];
    end
  end

  // single write port: toggle write-back or new-generation row
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_row_r;
    wr_data = s2_kept_r;
    if (state_r == S_CELL && req_r.kind == KIND_TOGGLE && req_inside) begin
      wr_en   = 1'b1;
      wr_addr = AW'(req_r.row);
      wr_data = row_bits ^ (ONE_BIT << AW'(req_r.col));
    end else if (s2_v_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= grid_mem[rd_addr];
  end

  // next-state row from the window; cells beyond the grid read as dead
  always_comb begin
    logic [GRID_SIZE-1:0] pl, pr, cl, cr, nl, nr;
    logic [3:0]           nb;
    incoming = (s1_row_r < IW'(GRID_SIZE) && rd_vld_r) ? rd_data_r : '0;
    pl = win_prev_r << 1;
    pr = win_prev_r >> 1;
    cl = win_cur_r << 1;
    cr = win_cur_r >> 1;
    nl = incoming << 1;
    nr = incoming >> 1;
    for (int c = 0; c < GRID_SIZE; c++) begin
      nb = 4'(pl[c]) + 4'(win_prev_r[c]) + 4'(pr[c]) + 4'(cl[c]) + 4'(cr[c])
         + 4'(nl[c]) + 4'(incoming[c]) + 4'(nr[c]);
      life_raw[c] = win_cur_r[c] ? (nb == 4'd2 || nb == 4'd3) : (nb == 4'd3);
    end
  end

  // outer ring: whole first/last row, first/last column elsewhere
  assign s1_edge   = (s1_row_r == IW'(1)) || (s1_row_r == IW'(GRID_SIZE));
  assign life_kept = s1_edge ? '0 : (life_raw & ~EDGE_COLS);
  assign s1_side   = 2'(life_raw[0]) + 2'(life_raw[GRID_SIZE-1]);

  // per-byte popcount lanes
  always_comb begin
    logic [PW-1:0] padded;
    padded = PW'(s2_raw_r);
    for (int l = 0; l < NL; l++) begin
      lane_cnt[l] = '0;
      for (int b = 0; b < 8; b++) begin
        lane_cnt[l] = lane_cnt[l] + 4'(padded[l*8+b]);
      end
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int l = 0; l < NL; l++) begin
      lane_sum = lane_sum + CW'(s3_lane_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      row_vld_r     <= '0;
      rd_vld_r      <= 1'b0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      gen_r         <= 32'd1;
      eaten_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_vld_r <= row_vld_r[rd_addr];
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end

      // sweep pipeline
      s1_v_r    <= (state_r == S_STEP);
      s2_v_r    <= s1_v_r && (s1_row_r != '0);
      s2_row_r  <= AW'(s1_row_r - IW'(1));
      s2_raw_r  <= life_raw;
      s2_kept_r <= life_kept;
      s2_edge_r <= s1_edge;
      s2_side_r <= s1_side;
      s3_v_r    <= s2_v_r;
      s3_lane_r <= lane_cnt;
      s3_edge_r <= s2_edge_r;
      s3_side_r <= s2_side_r;
      if (s1_v_r) begin
        win_prev_r <= win_cur_r;
        win_cur_r  <= incoming;
      end
      if (s3_v_r) begin
        live_acc_r  <= live_acc_r + LW'(lane_sum);
        eaten_acc_r <= eaten_acc_r + (s3_edge_r ? LW'(lane_sum) : LW'(s3_side_r));
      end

      // output register: loaded from S_DONE, emptied when the receiver takes it
      if (state_r == S_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            if (in_data.kind == KIND_STEP) begin
              idx_r       <= '0;
              win_prev_r  <= '0;
              win_cur_r   <= '0;
              live_acc_r  <= '0;
              eaten_acc_r <= '0;
              state_r     <= S_STEP;
            end else begin
              state_r <= S_CELL_RD;
            end
          end
        end
        S_CELL_RD: begin
          state_r <= S_CELL;
        end
        S_CELL: begin
          res_r.generation     <= gen_r;
          res_r.alive_estimate <= '0;
          case (req_r.kind)
            KIND_TOGGLE: res_r.cell_value <= req_inside & ~cur_bit;
            KIND_READ:   res_r.cell_value <= cur_bit;
            default:     res_r.cell_value <= 1'b0;
          endcase
          state_r <= S_DONE;
        end
        S_STEP: begin
          s1_row_r <= idx_r;
          if (idx_r == IW'(GRID_SIZE)) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            state_r <= S_FIN1;
          end
        end
        S_FIN1: begin
          eaten_total_r <= sat_add32(eaten_total_r, 32'(eaten_acc_r));
          state_r       <= S_FIN2;
        end
        S_FIN2: begin
          gen_r                <= gen_r + 32'd1;
          res_r.cell_value     <= 1'b0;
          res_r.generation     <= gen_r + 32'd1;
          res_r.alive_estimate <= sat_add32(32'(live_acc_r), eaten_total_r);
          state_r              <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // generation only ever advances by one
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(gen_r)) |-> (gen_r == $past(gen_r) + 32'd1))
    else $error("generation counter jumped");

  // eaten total never decreases
  a_eaten_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (eaten_total_r >= $past(eaten_total_r)))
    else $error("eaten total decreased");

  // memory is written only by a toggle or by the sweep
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CELL || state_r == S_STEP || state_r == S_DRAIN))
    else $error("row memory written outside toggle or sweep");

  // totals are folded in only after the sweep pipeline is empty
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN1) |-> (!s1_v_r && !s2_v_r && !s3_v_r))
    else $error("sweep pipeline busy at finish");

endmodule
